[hdl/sign_error_lms_adaptive_fir_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef SIGN_ERROR_LMS_ADAPTIVE_FIR_MACROS_SVH
`define SIGN_ERROR_LMS_ADAPTIVE_FIR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SELMS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SELMS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/selms_pkg.sv]
// constants and widths of the sign-error lms equalizer
// no dependencies
package selms_pkg;

    localparam int NUM_TAPS = 16;
    localparam int CNT_W    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

    localparam int SMP_W    = 16;
    localparam int TAP_W    = 24;
    localparam int STEP_W   = 24;
    localparam int LEAK_W   = 16;

    // shared multiplier operand and product widths
    localparam int MUL_A_W  = TAP_W + 1;
    localparam int MUL_B_W  = LEAK_W + 1;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    localparam int ACC_W    = MUL_P_W + CNT_W;
    localparam int LKV_W    = MUL_P_W - 24;
    localparam int UPD_W    = TAP_W + 3;

    localparam logic [TAP_W-1:0]  TAP_ONE      = TAP_W'(1 << 20);
    localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(3355);
    localparam logic [LEAK_W-1:0] LEAK_RESET   = LEAK_W'(168);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_RATE = 1'b1;

    // input item kinds (tuser)
    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_ADAPT = 1'b1;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

endpackage

[hdl/sign_error_lms_adaptive_fir.sv]
// sign-error lms adaptive fir equalizer, top level
// depends on selms_pkg
//
// Adaptive FIR equalizer with NUM_TAPS taps in Q3.20 and a window of the
// NUM_TAPS latest Q1.14 samples. A push item (tuser 0) shifts tdata[15:0]
// into the window and returns the rounded, saturated dot product of taps and
// window, with tuser high when it clipped. An adapt item (tuser 1) carries
// desired in tdata[31:16] and actual in tdata[47:32]; every tap leaks when
// large and moves by the sign of desired minus actual times step_size times
// its sample; the previous output is returned unchanged. Every item returns
// exactly one result. All arithmetic goes through one 25x17 signed
// multiplier with a registered product, driven by a small sequencer while
// tap and window registers rotate past it. A push forms one product per tap,
// then drains the last product and rounds it; an adapt forms a leak product,
// a magnitude compare product and a step product per tap, then updates it.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register until taken, and the next item is accepted
// meanwhile. Configuration writes are always taken.
module sign_error_lms_adaptive_fir
    import selms_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // input items
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,   // sample [15:0], desired [31:16], actual [47:32]
    input  logic                    s_tuser,   // kind
    // result items
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,   // filtered [15:0]
    output logic                    m_tuser,   // clipped
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [STEP_W-1:0]       cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_MAC_LAST,
        S_ROUND,
        S_AD_LEAK,
        S_AD_MAG,
        S_AD_STEP,
        S_AD_UPD,
        S_DONE
    } state_t;

    localparam logic [CNT_W-1:0]     LAST_CNT  = CNT_W'(NUM_TAPS - 1);
    localparam logic [CNT_W:0]       CENTER2   = (CNT_W + 1)'(NUM_TAPS - 1);
    localparam logic signed [MUL_P_W-1:0] LEAK_HALF = MUL_P_W'(64'sd1 <<< 23);
    localparam logic signed [MUL_P_W-1:0] ADJ_HALF  = MUL_P_W'(64'sd1 <<< 17);
    localparam logic signed [MUL_P_W-1:0] BIG_THR   = MUL_P_W'(64'sd1 <<< 21);
    localparam logic signed [ACC_W-1:0]   OUT_HALF  = ACC_W'(64'sd1 <<< 19);
    localparam logic signed [ACC_W-21:0]  Y_MAX     = (ACC_W - 20)'(32767);
    localparam logic signed [ACC_W-21:0]  Y_MIN     = -(ACC_W - 20)'(32768);
    localparam logic signed [UPD_W-1:0]   T_MAX     = UPD_W'(8388607);
    localparam logic signed [UPD_W-1:0]   T_MIN     = -UPD_W'(8388608);

    // sequencer and control
    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       step_neg_reg, step_neg_next;
    logic                       step_zero_reg, step_zero_next;

    // configuration
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [LEAK_W-1:0]          leak_rate_reg, leak_rate_next;

    // rotating tap and window lines, position 0 feeds the multiplier
    logic signed [TAP_W-1:0]    tap_reg [NUM_TAPS];
    logic signed [TAP_W-1:0]    tap_next [NUM_TAPS];
    logic signed [SMP_W-1:0]    win_reg [NUM_TAPS];
    logic signed [SMP_W-1:0]    win_next [NUM_TAPS];

    // datapath
    logic signed [MUL_P_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [LKV_W-1:0]    leak_reg, leak_next;
    logic signed [SMP_W-1:0]    last_out_reg, last_out_next;
    logic                       last_clip_reg, last_clip_next;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]       m_data_reg, m_data_next;
    logic                       m_user_reg, m_user_next;

    // shared multiplier
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;

    logic signed [TAP_W-1:0]    tap0;
    logic signed [SMP_W-1:0]    win0;
    logic signed [MUL_A_W-1:0]  tap_mag;
    logic signed [MUL_A_W-1:0]  step_op;
    logic [CNT_W:0]             two_i;
    logic [CNT_W:0]             dist2;

    logic signed [MUL_P_W-1:0]  leak_full;
    logic signed [MUL_P_W-1:0]  adj_full;
    logic signed [TAP_W-1:0]    adj_val;
    logic signed [UPD_W-1:0]    upd_sum;
    logic signed [TAP_W-1:0]    tap_new;
    logic signed [ACC_W-1:0]    y_full;
    logic signed [ACC_W-21:0]   y_val;

    logic signed [SMP_W-1:0]    in_sample;
    logic signed [SMP_W-1:0]    in_desired;
    logic signed [SMP_W-1:0]    in_actual;
    logic                       in_accept;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign in_accept  = s_tvalid && s_tready;
    assign in_sample  = $signed(s_tdata[15:0]);
    assign in_desired = $signed(s_tdata[31:16]);
    assign in_actual  = $signed(s_tdata[47:32]);

    assign tap0 = tap_reg[0];
    assign win0 = win_reg[0];

    // |tap| fits the positive range of the 25-bit operand
    assign tap_mag = tap0[TAP_W-1] ? -MUL_A_W'(tap0) : MUL_A_W'(tap0);

    // sign-error step as multiplier operand: +step, -step or zero
    assign step_op = step_zero_reg ? '0 :
                     step_neg_reg  ? -$signed({1'b0, step_reg}) :
                                     $signed({1'b0, step_reg});

    // twice the distance of tap cnt from the center
    assign two_i = {cnt_reg, 1'b0};
    assign dist2 = (two_i >= CENTER2) ? (two_i - CENTER2) : (CENTER2 - two_i);

    // operand select for the one multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MAC: begin
                mul_a = MUL_A_W'(tap0);
                mul_b = MUL_B_W'(win0);
            end
            S_AD_LEAK: begin
                mul_a = MUL_A_W'(tap0);
                mul_b = $signed({1'b0, leak_rate_reg});
            end
            S_AD_MAG: begin
                mul_a = tap_mag;
                mul_b = $signed(MUL_B_W'(dist2) + MUL_B_W'(2));
            end
            S_AD_STEP: begin
                mul_a = step_op;
                mul_b = MUL_B_W'(win0);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // rounding of the registered product, half up then floor
    assign leak_full = prod_reg + LEAK_HALF;
    assign adj_full  = prod_reg + ADJ_HALF;
    assign adj_val   = $signed(adj_full[MUL_P_W-1:18]);

    // tap update with saturation
    assign upd_sum = UPD_W'(tap0) - UPD_W'(leak_reg) + UPD_W'(adj_val);
    assign tap_new = (upd_sum > T_MAX) ? TAP_W'(T_MAX) :
                     (upd_sum < T_MIN) ? TAP_W'(T_MIN) : TAP_W'(upd_sum);

    // output rounding
    assign y_full = acc_reg + OUT_HALF;
    assign y_val  = $signed(y_full[ACC_W-1:20]);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_neg_next  = step_neg_reg;
        step_zero_next = step_zero_reg;
        step_next      = step_reg;
        leak_rate_next = leak_rate_reg;
        tap_next       = tap_reg;
        win_next       = win_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        leak_next      = leak_reg;
        last_out_next  = last_out_reg;
        last_clip_next = last_clip_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_STEP_SIZE: step_next      = cfg_data;
                REG_LEAK_RATE: leak_rate_next = cfg_data[LEAK_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    cnt_next = '0;
                    if (s_tuser == KIND_PUSH) begin
                        // shift the new sample in at the top
                        for (int i = 0; i < NUM_TAPS - 1; i++) begin
                            win_next[i] = win_reg[i + 1];
                        end
                        win_next[NUM_TAPS - 1] = in_sample;
                        state_next = S_MAC;
                    end else begin
                        step_neg_next  = (in_desired < in_actual);
                        step_zero_next = (in_desired == in_actual);
                        state_next     = S_AD_LEAK;
                    end
                end
            end
            S_MAC: begin
                // product of this tap, sum of the previous one; the first pass clears
                prod_next = mul_p;
                acc_next  = (cnt_reg == '0) ? '0 : (acc_reg + ACC_W'(prod_reg));
                for (int i = 0; i < NUM_TAPS - 1; i++) begin
                    tap_next[i] = tap_reg[i + 1];
                    win_next[i] = win_reg[i + 1];
                end
                tap_next[NUM_TAPS - 1] = tap0;
                win_next[NUM_TAPS - 1] = win0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT) begin
                    state_next = S_MAC_LAST;
                end
            end
            S_MAC_LAST: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = S_ROUND;
            end
            S_ROUND: begin
                if (y_val > Y_MAX) begin
                    last_out_next  = SMP_W'(Y_MAX);
                    last_clip_next = 1'b1;
                end else if (y_val < Y_MIN) begin
                    last_out_next  = SMP_W'(Y_MIN);
                    last_clip_next = 1'b1;
                end else begin
                    last_out_next  = SMP_W'(y_val);
                    last_clip_next = 1'b0;
                end
                state_next = S_DONE;
            end
            S_AD_LEAK: begin
                prod_next  = mul_p;
                state_next = S_AD_MAG;
            end
            S_AD_MAG: begin
                leak_next  = $signed(leak_full[MUL_P_W-1:24]);
                prod_next  = mul_p;
                state_next = S_AD_STEP;
            end
            S_AD_STEP: begin
                // small taps do not leak
                if (prod_reg < BIG_THR) begin
                    leak_next = '0;
                end
                prod_next  = mul_p;
                state_next = S_AD_UPD;
            end
            S_AD_UPD: begin
                for (int i = 0; i < NUM_TAPS - 1; i++) begin
                    tap_next[i] = tap_reg[i + 1];
                    win_next[i] = win_reg[i + 1];
                end
                tap_next[NUM_TAPS - 1] = tap_new;
                win_next[NUM_TAPS - 1] = win0;
                cnt_next = cnt_reg + 1'b1;
                state_next = (cnt_reg == LAST_CNT) ? S_DONE : S_AD_LEAK;
            end
            S_DONE: begin
                // wait for room in the output register
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = last_out_reg;
                    m_user_next  = last_clip_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            step_neg_reg  <= 1'b0;
            step_zero_reg <= 1'b1;
            step_reg      <= STEP_RESET;
            leak_rate_reg <= LEAK_RESET;
            for (int i = 0; i < NUM_TAPS; i++) begin
                tap_reg[i] <= (i == NUM_TAPS / 2) ? TAP_ONE : '0;
                win_reg[i] <= '0;
            end
            last_out_reg  <= '0;
            last_clip_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_neg_reg  <= step_neg_next;
            step_zero_reg <= step_zero_next;
            step_reg      <= step_next;
            leak_rate_reg <= leak_rate_next;
            tap_reg       <= tap_next;
            win_reg       <= win_next;
            last_out_reg  <= last_out_next;
            last_clip_reg <= last_clip_next;
            m_valid_reg   <= m_valid_next;
        end
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        leak_reg   <= leak_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

[hdl/selms_checker.sv]
// port-level checks for the sign-error lms equalizer, bound to the top level
// depends on selms_pkg and sign_error_lms_adaptive_fir_macros.svh
`include "sign_error_lms_adaptive_fir_macros.svh"

module selms_checker
    import selms_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_W-1:0]    m_tdata,
    input  logic                    m_tuser
);

    // an accepted item keeps the block busy for at least the next cycle
    `SELMS_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready high right after an accepted item")

    // a clipped result sits at one of the rails
    `SELMS_ASSERT_IMP(a_clip_at_rail, aclk, aresetn, m_tvalid && m_tuser, (m_tdata == 16'h7fff) || (m_tdata == 16'h8000), "clipped result not at a rail")

    // a stalled result holds
    `SELMS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind sign_error_lms_adaptive_fir selms_checker u_selms_checker (.*);

[bench/tb_sign_error_lms_adaptive_fir.sv]
// self-checking bench for the sign-error lms adaptive fir equalizer
// depends on selms_pkg and sign_error_lms_adaptive_fir; holds its own tap/window shadow
`timescale 1ns / 100ps

module tb_sign_error_lms_adaptive_fir;
    import selms_pkg::*;

    localparam int     SETTLE_CYCLES  = 4 * NUM_TAPS + 16;  // longer than one adapt pass
    localparam int     LONG_HOLD      = 300;
    localparam int     HOLD_AFTER     = 400;   // results taken before the long hold
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     PHASE_ITEMS    = 240;
    localparam longint TAP_HI = (longint'(1) << (TAP_W - 1)) - 1;
    localparam longint TAP_LO = -(longint'(1) << (TAP_W - 1));
    localparam longint OUT_HI = 32767;
    localparam longint OUT_LO = -32768;

    typedef struct packed {
        logic [SMP_W-1:0] filtered;
        logic             clipped;
    } fir_result_t;

    // shadow of the equalizer: window, taps, held output and both registers
    class equalizer_tracker;
        logic signed [SMP_W-1:0] window [NUM_TAPS];
        logic signed [TAP_W-1:0] taps [NUM_TAPS];
        logic signed [SMP_W-1:0] held_output;
        logic                    held_clip;
        logic [STEP_W-1:0]       step_size;
        logic [LEAK_W-1:0]       leak_rate;
        fir_result_t             expected_results [$];
        int                      mismatches;
        int                      results_seen;

        function new();
            for (int i = 0; i < NUM_TAPS; i++) begin
                window[i] = '0;
                taps[i]   = '0;
            end
            taps[NUM_TAPS / 2] = TAP_ONE;
            held_output  = '0;
            held_clip    = 1'b0;
            step_size    = STEP_RESET;
            leak_rate    = LEAK_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // add half an lsb, then floor
        static function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [STEP_W-1:0] value);
            case (index)
                REG_STEP_SIZE: step_size = value;
                REG_LEAK_RATE: leak_rate = value[LEAK_W-1:0];
                default: ;
            endcase
        endfunction

        // update the shadow for one accepted item and queue the result it returns
        function void note_item(logic kind, logic [S_TDATA_W-1:0] data);
            longint acc, y, des, act, sgn, t, mag, d2, leak, adj;
            if (kind == KIND_PUSH) begin
                for (int i = 0; i < NUM_TAPS - 1; i++) window[i] = window[i + 1];
                window[NUM_TAPS - 1] = data[15:0];
                acc = 0;
                for (int i = 0; i < NUM_TAPS; i++)
                    acc += longint'(taps[i]) * longint'(window[i]);
                y = round_shift(acc, 20);
                held_clip   = (y > OUT_HI) || (y < OUT_LO);
                held_output = SMP_W'(clamp(y, OUT_LO, OUT_HI));
            end else begin
                des = longint'($signed(data[31:16]));
                act = longint'($signed(data[47:32]));
                sgn = (des > act) ? 1 : ((des < act) ? -1 : 0);
                for (int i = 0; i < NUM_TAPS; i++) begin
                    t   = taps[i];
                    mag = (t < 0) ? -t : t;
                    d2  = 2 * i - (NUM_TAPS - 1);
                    if (d2 < 0) d2 = -d2;
                    // large taps: |tap| >= 1/(1+d), compared exactly
                    leak = 0;
                    if (mag * (2 + d2) >= 2 * longint'(TAP_ONE))
                        leak = round_shift(t * longint'(leak_rate), 24);
                    adj = round_shift(sgn * longint'(step_size) * longint'(window[i]), 18);
                    taps[i] = TAP_W'(clamp(t - leak + adj, TAP_LO, TAP_HI));
                end
            end
            // an adapt item hands back the held output untouched
            expected_results.push_back('{filtered: held_output, clipped: held_clip});
        endfunction

        function void check_result(logic [SMP_W-1:0] filtered, logic clipped);
            fir_result_t want;
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result item: filtered %0d clipped %0b",
                       $signed(filtered), clipped);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (filtered !== want.filtered) begin
                $error("filtered: expected %0d, got %0d",
                       $signed(want.filtered), $signed(filtered));
                mismatches++;
            end
            if (clipped !== want.clipped) begin
                $error("clipped: expected %0b, got %0b", want.clipped, clipped);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // sample [15:0], desired [31:16], actual [47:32]
    logic                  s_tuser;   // kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // filtered [15:0]
    logic                  m_tuser;   // clipped
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [STEP_W-1:0]     cfg_data;

    equalizer_tracker shadow = new();

    int send_calm = 0;      // items left in a no-gap stretch, sender side
    int take_calm = 0;      // same, receiver side
    int quiet_cycles = 0;
    bit held_off = 1'b0;

    sign_error_lms_adaptive_fir dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // cycles of idling before the next item; now and then a run of back-to-back items
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 30);
        return $urandom_range(0, 9);
    endfunction

    // offer one item; valid stays high across back-to-back items
    task automatic send_item(logic kind, logic [15:0] smp, logic [15:0] dsr,
                             logic [15:0] act);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= kind;
        s_tdata  <= {act, dsr, smp};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        shadow.note_item(kind, {act, dsr, smp});
    endtask

    task automatic wait_results();
        while (shadow.expected_results.size() != 0) @(posedge aclk);
    endtask

    // stop offering, let every result come back, then give the sequencer time to go idle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both registers back to back, valid held high in between
    task automatic write_settings(logic [STEP_W-1:0] step, logic [LEAK_W-1:0] leak);
        cfg_index <= REG_STEP_SIZE;
        cfg_data  <= step;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        shadow.set_register(REG_STEP_SIZE, step);
        cfg_index <= REG_LEAK_RATE;
        cfg_data  <= STEP_W'(leak);
        do @(posedge aclk); while (!cfg_ready);
        shadow.set_register(REG_LEAK_RATE, STEP_W'(leak));
        cfg_valid <= 1'b0;
    endtask

    // random items under one setting: mostly pushes and decision-directed adapts
    // (actual is the block's own output, desired its sliced value), some raw noise
    task automatic run_phase(int count, logic [STEP_W-1:0] step, logic [LEAK_W-1:0] leak);
        logic [15:0] smp, dsr, act;
        int pick;
        write_settings(step, leak);
        for (int n = 0; n < count; n++) begin
            // once per phase the sender waits for every result to come back
            if (n == (count * 3) / 4) begin
                s_tvalid <= 1'b0;
                wait_results();
            end
            smp  = 16'($urandom);
            dsr  = 16'($urandom);
            act  = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // mostly moderate samples, a quarter across the full range
                if ($urandom_range(0, 3) != 0) smp = 16'($urandom_range(0, 24000)) - 16'd12000;
                send_item(KIND_PUSH, smp, dsr, act);
            end else if (pick < 88) begin
                act = shadow.held_output;
                if ($urandom_range(0, 7) == 0)
                    dsr = act;
                else
                    dsr = shadow.held_output[15] ? 16'hC000 : 16'h4000;
                send_item(KIND_ADAPT, smp, dsr, act);
            end else begin
                send_item(KIND_ADAPT, smp, dsr, act);
            end
        end
        quiesce();
    endtask

    // receiver: random stalls, plus one long hold that backs the block up to its input
    initial begin
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_wait(take_calm);
            if (!held_off && shadow.results_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            shadow.check_result(m_tdata, m_tuser);
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_sign_error_lms_adaptive_fir: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_PUSH;
        cfg_valid <= 1'b0;
        cfg_index <= REG_STEP_SIZE;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: adapt before any push returns zero, equal error still leaks,
        // the center tap of one sits above the leak threshold (half-lsb leak)
        send_item(KIND_ADAPT, 16'h0000, 16'h0000, 16'h0000);
        send_item(KIND_ADAPT, 16'h0000, 16'h0064, 16'h0000);
        send_item(KIND_PUSH,  16'h7FFF, 16'h0000, 16'h0000);
        send_item(KIND_PUSH,  16'h8000, 16'hFFFF, 16'hFFFF);
        send_item(KIND_PUSH,  16'h0001, 16'h0000, 16'h0000);
        send_item(KIND_PUSH,  16'hFFFF, 16'h0000, 16'h0000);
        send_item(KIND_PUSH,  16'h4000, 16'h0000, 16'h0000);
        send_item(KIND_PUSH,  16'hC000, 16'h0000, 16'h0000);
        send_item(KIND_PUSH,  16'h0000, 16'h0000, 16'h0000);
        send_item(KIND_PUSH,  16'h3039, 16'h0000, 16'h0000);
        send_item(KIND_PUSH,  16'hFFF9, 16'h0000, 16'h0000);
        send_item(KIND_PUSH,  16'h7FFF, 16'h0000, 16'h0000);
        send_item(KIND_ADAPT, 16'h0000, 16'h7FFF, 16'h8000);   // error positive
        send_item(KIND_ADAPT, 16'h0000, 16'h8000, 16'h7FFF);   // error negative
        send_item(KIND_ADAPT, 16'h0000, 16'h0005, 16'h0005);   // no error
        quiesce();

        // largest step and leak: taps run into saturation, outputs clip both ways
        write_settings({STEP_W{1'b1}}, {LEAK_W{1'b1}});
        repeat (4) send_item(KIND_ADAPT, 16'h0000, 16'h7FFF, 16'h8000);
        send_item(KIND_PUSH,  16'h7FFF, 16'h0000, 16'h0000);
        send_item(KIND_PUSH,  16'h8000, 16'h0000, 16'h0000);
        repeat (2) send_item(KIND_ADAPT, 16'h0000, 16'h8000, 16'h7FFF);
        send_item(KIND_PUSH,  16'h0000, 16'h0000, 16'h0000);
        send_item(KIND_PUSH,  16'h8000, 16'h0000, 16'h0000);
        quiesce();

        run_phase(PHASE_ITEMS, STEP_RESET, LEAK_RESET);
        run_phase(PHASE_ITEMS, '0, '0);
        run_phase(PHASE_ITEMS, STEP_W'($urandom_range(1, 200000)), LEAK_W'($urandom));
        run_phase(PHASE_ITEMS, {STEP_W{1'b1}}, {LEAK_W{1'b1}});

        if (shadow.mismatches == 0 && shadow.expected_results.size() == 0)
            $display("tb_sign_error_lms_adaptive_fir: done, clean");
        else
            $display("tb_sign_error_lms_adaptive_fir: done, errors");
        $finish;
    end

endmodule
